FILE: rtl/depth_outlier_gaussian_filter_defines.svh
// Assertion macros shared by the depth outlier filter RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef DEPTH_OUTLIER_GAUSSIAN_FILTER_DEFINES_SVH
`define DEPTH_OUTLIER_GAUSSIAN_FILTER_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define DOGF_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define DOGF_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dogf_pkg.sv
// Package of the depth outlier filter: sizes, codes, shared types and helpers.
// Depends on nothing; the interfaces, dogf_dot and the top filter import it.
`default_nettype none
package dogf_pkg;

	localparam int MAX_LINE      = 1024;
	localparam int MAX_RADIUS    = 8;
	localparam int DEPTH_BITS    = 24;
	localparam int TAP_FRAC_BITS = 16;

	localparam int LANES   = 2 * MAX_RADIUS + 1;
	localparam int BANKS   = 2 * MAX_RADIUS;
	localparam int RAW_LEN = MAX_RADIUS * MAX_LINE + MAX_RADIUS;

	localparam int COL_W  = $clog2(MAX_LINE);
	localparam int ROW_W  = 16;
	localparam int W_W    = 11;
	localparam int R_W    = 4;
	localparam int MIN_W  = 5;
	localparam int THR_W  = 23;
	localparam int TAP_W  = 18;
	localparam int TIDX_W = 4;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 23;

	localparam int DATA_W  = 32;
	localparam int PROD_W  = TAP_W + 1 + DATA_W;
	localparam int PART_N  = (LANES + 3) / 4;
	localparam int PART_W  = PROD_W + 2;
	localparam int SUM_W   = PROD_W + $clog2(LANES);
	localparam int CNT_W   = $clog2(LANES + 1);
	localparam int LANE_W  = $clog2(LANES);
	localparam int BANK_W  = $clog2(BANKS);
	localparam int DIST_W  = $clog2(MAX_RADIUS + 1);
	localparam int RAW_AW  = $clog2(RAW_LEN);
	localparam int PCNT_W  = ROW_W + COL_W;
	localparam int DLY_W   = R_W + W_W;
	localparam int HENT_W  = DATA_W + 1;
	localparam int DIFF_W  = SUM_W - TAP_FRAC_BITS + 1;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [CFG_AW-1:0] REG_WIDTH     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_RADIUS    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_MIN_TAPS  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd4;

	typedef logic signed [DATA_W-1:0] lane_data_t;
	typedef logic [TAP_W-1:0] tap_t;

	// Distance of a lane from the kernel centre; distances beyond MAX_RADIUS map to tap index zero.
	function automatic logic [DIST_W-1:0] tap_dist(input logic [LANE_W-1:0] lane,
			input logic [R_W-1:0] r);
		logic [LANE_W-1:0] d;
		d = (lane > LANE_W'(r)) ? lane - LANE_W'(r) : LANE_W'(r) - lane;
		tap_dist = (d > LANE_W'(MAX_RADIUS)) ? '0 : DIST_W'(d);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/dogf_if.sv
// Channel interfaces of the depth outlier filter: pixel input, result output, register writes.
// Depends on dogf_pkg.
`default_nettype none
interface dogf_pix_if import dogf_pkg::*; ();
	logic                         valid;
	logic                         ready;
	action_t                      action;
	logic [TIDX_W-1:0]            tap_index;
	logic [TAP_W-1:0]             tap_value;
	logic signed [DEPTH_BITS-1:0] depth_in;
	logic                         depth_in_valid;

	modport source (output valid, action, tap_index, tap_value, depth_in, depth_in_valid,
		input ready);
	modport sink (input valid, action, tap_index, tap_value, depth_in, depth_in_valid,
		output ready);
endinterface

interface dogf_res_if import dogf_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DEPTH_BITS-1:0] depth_out;
	logic                         depth_out_valid;
	logic [ROW_W-1:0]             out_row;
	logic [COL_W-1:0]             out_col;

	modport source (output valid, depth_out, depth_out_valid, out_row, out_col, input ready);
	modport sink (input valid, depth_out, depth_out_valid, out_row, out_col, output ready);
endinterface

interface dogf_cfg_if import dogf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dogf_dot.sv
// Seventeen-lane masked dot product with a registered adder tree: products, partial sums and total.
// Depends on dogf_pkg; used for both the horizontal and the vertical pass.
`default_nettype none
module dogf_dot import dogf_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  lane_data_t              data [LANES],
	input  logic [LANES-1:0]        mask,
	input  tap_t                    tap [LANES],
	output logic signed [SUM_W-1:0] sum,
	output logic [CNT_W-1:0]        cnt
);

	logic signed [PROD_W-1:0] prod_s1 [LANES];
	logic signed [PART_W-1:0] part_s2 [PART_N];
	logic signed [PART_W-1:0] part_d [PART_N];
	logic signed [SUM_W-1:0]  sum_d;
	logic [CNT_W-1:0]         cnt_s1;
	logic [CNT_W-1:0]         cnt_s2;

	always_comb begin
		for (int g = 0; g < PART_N; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < 4; k++) begin
				if (g * 4 + k < LANES) begin
					part_d[g] = part_d[g] + PART_W'(prod_s1[g * 4 + k]);
				end
			end
		end
		sum_d = '0;
		for (int g = 0; g < PART_N; g++) begin
			sum_d = sum_d + SUM_W'(part_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				if (mask[i]) begin
					prod_s1[i] <= $signed({1'b0, tap[i]}) * data[i];
				end else begin
					prod_s1[i] <= '0;
				end
			end
			cnt_s1 <= CNT_W'($countones(mask));
			part_s2 <= part_d;
			cnt_s2 <= cnt_s1;
			sum <= sum_d;
			cnt <= cnt_s2;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/depth_outlier_gaussian_filter.sv
// Path: an item that is taken passes the stages st_s1 to st_s9 before its result enters the
// output buffer; in items a result trails its pixel by radius rows plus radius pixels.
// Throughput: one item per cycle while not stalled, set by one read and one write per line
// memory per item. Reset clears the counters, window flags, pipeline and output buffer at once;
// the tap table and both line memories hold undefined data until written and are never swept.
`default_nettype none
`include "depth_outlier_gaussian_filter_defines.svh"
module depth_outlier_gaussian_filter import dogf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dogf_pix_if.sink   pixel,
	dogf_res_if.source result,
	dogf_cfg_if.sink   cfg
);

	typedef struct packed {
		logic                  load;
		logic [DIST_W-1:0]     tidx;
		tap_t                  tval;
		logic                  emit;
		logic                  blur;
		logic                  have_h;
		logic                  hv_form;
		logic [COL_W-1:0]      hcol;
		logic [BANK_W-1:0]     bank;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic [DEPTH_BITS:0]   raw;
	} item_t;

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth;
		logic                  ok;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
	} res_t;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (TAP_FRAC_BITS - 1));
	localparam logic signed [SUM_W-1:0] HMAX = {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] HMIN = {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

	logic [W_W-1:0]   w_q;
	logic [ROW_W-1:0] h_q;
	logic [R_W-1:0]   r_q;
	logic [MIN_W-1:0] min_q;
	logic [THR_W-1:0] thr_q;
	logic [W_W-1:0]   w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [R_W-1:0]   r_eff;
	logic [R_W:0]     r2;
	logic [DLY_W-1:0] dly;

	logic [ROW_W-1:0]  in_row_q, em_row_q, in_row_n, em_row_n;
	logic [COL_W-1:0]  in_col_q, em_col_q, in_col_n, em_col_n;
	logic [PCNT_W-1:0] pcnt_q;
	logic [RAW_AW-1:0] wp_q, rp_q;
	logic [BANK_W-1:0] hbank_q;
	logic              in_wrap, em_wrap;

	logic adv, acc, is_pix, is_flush, is_load, do_emit, interior, frame_done;

	logic signed [DEPTH_BITS-1:0] win_d_q [LANES];
	logic [LANES-1:0]             win_ok_q;
	tap_t                         htap_q [MAX_RADIUS + 1];
	tap_t                         vtap_q [MAX_RADIUS + 1];

	logic [DEPTH_BITS:0] raw_mem [RAW_LEN];
	logic [DEPTH_BITS:0] raw_rd_s1;
	logic [HENT_W-1:0]   hmem [BANKS][MAX_LINE];
	logic [HENT_W-1:0]   hrd_s5 [BANKS];

	item_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8, st_s9, st_in, s1_full;

	lane_data_t             h_data [LANES];
	logic [LANES-1:0]       h_mask;
	tap_t                   h_tap [LANES];
	logic signed [SUM_W-1:0] hsum, vsum;
	logic [CNT_W-1:0]       hcnt, vcnt;
	logic signed [SUM_W-1:0] hsum_rnd, vsum_rnd;
	logic signed [DATA_W-1:0] hv_sat;
	logic                   hv_ok;
	logic [HENT_W-1:0]      hent;
	logic signed [DATA_W-1:0] hv_s5;
	logic                   hv_ok_s5;

	lane_data_t             v_data [LANES];
	logic [LANES-1:0]       v_mask;
	tap_t                   v_tap [LANES];
	logic [BANK_W:0]        vi;
	logic [HENT_W-1:0]      vent;

	logic signed [DIFF_W-1:0] diff_s9;
	logic                   blur_ok_s9;
	logic [DIFF_W-1:0]      absd;

	res_t       ob_q [2];
	res_t       nw;
	logic [1:0] cnt_q;
	logic       push, pop;

	// Effective register values.
	always_comb begin
		w_eff = (w_q == '0) ? W_W'(1) : ((w_q > W_W'(MAX_LINE)) ? W_W'(MAX_LINE) : w_q);
		h_eff = (h_q == '0) ? ROW_W'(1) : h_q;
		r_eff = (r_q == '0) ? R_W'(1) : ((r_q > R_W'(MAX_RADIUS)) ? R_W'(MAX_RADIUS) : r_q);
		r2 = {r_eff, 1'b0};
		dly = DLY_W'(r_eff) * DLY_W'(w_eff) + DLY_W'(r_eff);
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_W'(1024);
			h_q <= ROW_W'(1024);
			r_q <= R_W'(5);
			min_q <= MIN_W'(1);
			thr_q <= THR_W'(256);
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_WIDTH: w_q <= cfg.data[W_W-1:0];
				REG_HEIGHT: h_q <= cfg.data[ROW_W-1:0];
				REG_RADIUS: r_q <= cfg.data[R_W-1:0];
				REG_MIN_TAPS: min_q <= cfg.data[MIN_W-1:0];
				REG_THRESHOLD: thr_q <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Item decode at the transfer.
	assign adv = (cnt_q != 2'd2);
	assign pixel.ready = adv;
	assign acc = pixel.valid && adv;
	assign is_pix = acc && (pixel.action == ACT_PIXEL) && (in_row_q < h_eff);
	assign is_flush = acc && (pixel.action == ACT_FLUSH) && (in_row_q >= h_eff);
	assign is_load = acc && (pixel.action == ACT_LOAD) && (pixel.tap_index <= TIDX_W'(MAX_RADIUS));
	assign do_emit = is_flush || (is_pix && (pcnt_q >= PCNT_W'(dly)));

	always_comb begin
		interior = (em_col_q >= COL_W'(r_eff))
			&& ((W_W'(em_col_q) + W_W'(r_eff)) < w_eff)
			&& (em_row_q >= ROW_W'(r_eff))
			&& (({1'b0, em_row_q} + (ROW_W + 1)'(r_eff)) < {1'b0, h_eff});
		in_wrap = (W_W'(in_col_q) + W_W'(1)) >= w_eff;
		em_wrap = (W_W'(em_col_q) + W_W'(1)) >= w_eff;
		in_col_n = in_wrap ? '0 : in_col_q + COL_W'(1);
		in_row_n = in_wrap ? in_row_q + ROW_W'(1) : in_row_q;
		em_col_n = em_wrap ? '0 : em_col_q + COL_W'(1);
		em_row_n = em_wrap ? em_row_q + ROW_W'(1) : em_row_q;
		frame_done = do_emit && em_wrap
			&& (({1'b0, em_row_q} + (ROW_W + 1)'(1)) >= {1'b0, h_eff});

		st_in = '0;
		st_in.load = is_load;
		st_in.tidx = DIST_W'(pixel.tap_index);
		st_in.tval = pixel.tap_value;
		st_in.emit = do_emit;
		st_in.blur = is_pix && do_emit && interior;
		st_in.have_h = is_pix && (in_col_q >= COL_W'(r_eff));
		st_in.hv_form = (in_col_q >= COL_W'(r2)) && (in_row_q >= ROW_W'(r_eff))
			&& (({1'b0, in_row_q} + (ROW_W + 1)'(r_eff)) < {1'b0, h_eff});
		st_in.hcol = in_col_q - COL_W'(r_eff);
		st_in.bank = hbank_q;
		st_in.row = em_row_q;
		st_in.col = em_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			em_row_q <= '0;
			em_col_q <= '0;
			pcnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
			hbank_q <= '0;
			win_ok_q <= '0;
		end else begin
			if (is_pix) begin
				win_ok_q <= {win_ok_q[LANES-2:0], pixel.depth_in_valid};
			end
			if (frame_done) begin
				in_row_q <= '0;
				in_col_q <= '0;
				em_row_q <= '0;
				em_col_q <= '0;
				pcnt_q <= '0;
				wp_q <= '0;
				rp_q <= '0;
				hbank_q <= '0;
			end else begin
				if (is_pix) begin
					in_col_q <= in_col_n;
					in_row_q <= in_row_n;
					pcnt_q <= pcnt_q + PCNT_W'(1);
					wp_q <= (wp_q == RAW_AW'(RAW_LEN - 1)) ? '0 : wp_q + RAW_AW'(1);
					if (in_wrap) begin
						hbank_q <= ((BANK_W + 1)'(hbank_q) + (BANK_W + 1)'(1) == r2)
							? '0 : hbank_q + BANK_W'(1);
					end
				end
				if (do_emit) begin
					em_col_q <= em_col_n;
					em_row_q <= em_row_n;
					rp_q <= (rp_q == RAW_AW'(RAW_LEN - 1)) ? '0 : rp_q + RAW_AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_pix) begin
			win_d_q[0] <= pixel.depth_in;
			for (int j = 1; j < LANES; j++) begin
				win_d_q[j] <= win_d_q[j - 1];
			end
		end
	end

	// Raw delay line: read-before-write, so a slot read and rewritten together gives the old pixel.
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_rd_s1 <= raw_mem[rp_q];
			if (is_pix) begin
				raw_mem[wp_q] <= {pixel.depth_in_valid, pixel.depth_in};
			end
		end
	end

	always_comb begin
		s1_full = st_s1;
		s1_full.raw = raw_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
			st_s2 <= '0;
			st_s3 <= '0;
			st_s4 <= '0;
			st_s5 <= '0;
			st_s6 <= '0;
			st_s7 <= '0;
			st_s8 <= '0;
			st_s9 <= '0;
		end else if (adv) begin
			st_s1 <= st_in;
			st_s2 <= s1_full;
			st_s3 <= st_s2;
			st_s4 <= st_s3;
			st_s5 <= st_s4;
			st_s6 <= st_s5;
			st_s7 <= st_s6;
			st_s8 <= st_s7;
			st_s9 <= st_s8;
		end
	end

	// Each pass takes tap loads in stream order at the stage where it reads the taps.
	always_ff @(posedge clk) begin
		if (adv && st_s1.load) begin
			htap_q[st_s1.tidx] <= st_s1.tval;
		end
		if (adv && st_s5.load) begin
			vtap_q[st_s5.tidx] <= st_s5.tval;
		end
	end

	// Horizontal pass over the pixel window.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			h_data[j] = DATA_W'(win_d_q[j]);
			h_mask[j] = win_ok_q[j] && (LANE_W'(j) <= LANE_W'(r2));
			h_tap[j] = htap_q[tap_dist(LANE_W'(j), r_eff)];
		end
	end

	dogf_dot u_hdot (
		.clk  (clk),
		.en   (adv),
		.data (h_data),
		.mask (h_mask),
		.tap  (h_tap),
		.sum  (hsum),
		.cnt  (hcnt)
	);

	always_comb begin
		hsum_rnd = (hsum + HALF) >>> TAP_FRAC_BITS;
		if (hsum_rnd > HMAX) begin
			hv_sat = {1'b0, {(DATA_W - 1){1'b1}}};
		end else if (hsum_rnd < HMIN) begin
			hv_sat = {1'b1, {(DATA_W - 1){1'b0}}};
		end else begin
			hv_sat = hsum_rnd[DATA_W-1:0];
		end
		hv_ok = st_s4.hv_form && (hcnt >= CNT_W'(min_q));
		hent = {hv_ok, hv_ok ? hv_sat : DATA_W'(0)};
	end

	// Line memories of horizontal results, one bank per row slot, all read at the same column.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int b = 0; b < BANKS; b++) begin
				hrd_s5[b] <= hmem[b][st_s4.hcol];
				if (st_s4.have_h && (st_s4.bank == BANK_W'(b))) begin
					hmem[b][st_s4.hcol] <= hent;
				end
			end
			hv_s5 <= hent[DATA_W-1:0];
			hv_ok_s5 <= hv_ok;
		end
	end

	// Vertical pass: rotate banks so that lane zero holds the oldest row.
	always_comb begin
		vi = '0;
		vent = '0;
		for (int j = 0; j < BANKS; j++) begin
			vi = {1'b0, st_s5.bank} + (BANK_W + 1)'(j);
			if (vi >= r2) begin
				vi = vi - r2;
			end
			vent = hrd_s5[vi[BANK_W-1:0]];
			v_data[j] = vent[DATA_W-1:0];
			v_mask[j] = vent[DATA_W] && (LANE_W'(j) < LANE_W'(r2));
			v_tap[j] = vtap_q[tap_dist(LANE_W'(j), r_eff)];
		end
		v_data[LANES-1] = hv_s5;
		v_mask[LANES-1] = hv_ok_s5;
		v_tap[LANES-1] = vtap_q[DIST_W'(r_eff)];
	end

	dogf_dot u_vdot (
		.clk  (clk),
		.en   (adv),
		.data (v_data),
		.mask (v_mask),
		.tap  (v_tap),
		.sum  (vsum),
		.cnt  (vcnt)
	);

	assign vsum_rnd = (vsum + HALF) >>> TAP_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s9 <= DIFF_W'($signed(st_s8.raw[DEPTH_BITS-1:0])) - DIFF_W'(vsum_rnd);
			blur_ok_s9 <= st_s8.blur && (vcnt >= CNT_W'(min_q));
		end
	end

	always_comb begin
		absd = diff_s9[DIFF_W-1] ? DIFF_W'(-diff_s9) : DIFF_W'(diff_s9);
		nw.depth = st_s9.raw[DEPTH_BITS-1:0];
		nw.ok = st_s9.raw[DEPTH_BITS] && blur_ok_s9 && (absd <= DIFF_W'(thr_q));
		nw.row = st_s9.row;
		nw.col = st_s9.col;
	end

	// Two-entry output buffer.
	assign push = adv && st_s9.emit;
	assign pop = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			ob_q[0] <= nw;
		end else if (pop) begin
			ob_q[0] <= ob_q[1];
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			ob_q[1] <= nw;
		end
	end

	assign result.valid = (cnt_q != 2'd0);
	assign result.depth_out = ob_q[0].depth;
	assign result.depth_out_valid = ob_q[0].ok;
	assign result.out_row = ob_q[0].row;
	assign result.out_col = ob_q[0].col;

	`DOGF_CHECK(a_valid_drops_on_transfer, $fell(result.valid) |-> $past(result.ready), "result valid fell without a transfer")
	`DOGF_CHECK_NEXT(a_push_shows, push && !pop, result.valid, "pushed result not presented")
	`DOGF_CHECK_NEXT(a_frame_restart, frame_done, in_row_q == '0 && pcnt_q == '0 && rp_q == '0, "counters not cleared at frame end")
	`DOGF_CHECK_NEXT(a_stall_holds, !adv, $stable(st_s9), "pipeline moved while stalled")

endmodule
`default_nettype wire
